[design/frame_flip_rotate_invert_defines.svh]
// ---------------------------------------------------------------------------
// Frame flip / rotate / invert: assertion macros
// Shared concurrent assertion wrappers. They are empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef FRAME_FLIP_ROTATE_INVERT_DEFINES_SVH
`define FRAME_FLIP_ROTATE_INVERT_DEFINES_SVH

`ifndef SYNTHESIS
`define FFRI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("frame_flip_rotate_invert: assertion failed");
`define FFRI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("frame_flip_rotate_invert: assertion failed");
`else
`define FFRI_ASSERT_IMP(lbl, ante, cons)
`define FFRI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/ffri_pkg.sv]
// ---------------------------------------------------------------------------
// Frame flip / rotate / invert: package
// Field widths, register indexes, operation and status codes, stage control.
// ---------------------------------------------------------------------------
package ffri_pkg;

	localparam int CHAN_W     = 16;
	localparam int DIM_CFG_W  = 9;
	localparam int LEVEL_W    = 16;
	localparam int OP_W       = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int STATUS_W   = 2;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_FRAME_WIDTH  = 3'd0;
	localparam reg_idx_t REG_FRAME_HEIGHT = 3'd1;
	localparam reg_idx_t REG_MAX_LEVEL    = 3'd2;
	localparam reg_idx_t REG_OPERATION    = 3'd3;
	localparam reg_idx_t REG_COLOR_MODE   = 3'd4;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_INVERT   = 3'd0;
	localparam op_t OP_MIRROR_H = 3'd1;
	localparam op_t OP_MIRROR_V = 3'd2;
	localparam op_t OP_ROT90    = 3'd3;
	localparam op_t OP_ROT270   = 3'd4;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_READY = 2'd1;
	localparam status_t ST_CLAMPED   = 2'd2;

	typedef struct packed {
		logic               ready;
		logic               last;
		logic               clamp;
		logic               gray;
		logic               inv;
		logic [LEVEL_W-1:0] level;
	} rd_ctl_t;

endpackage

[design/ffri_store.sv]
// ---------------------------------------------------------------------------
// Frame flip / rotate / invert: frame store
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ffri_store #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[design/frame_flip_rotate_invert.sv]
// ---------------------------------------------------------------------------
// Frame flip / rotate / invert
// Loads one frame in raster order and reads it back inverted, mirrored or
// rotated.
// ---------------------------------------------------------------------------
// The block takes one word in every cycle and busy stays low. A load word
// (func 0) gives no result. A read word (func 1) gives exactly one result,
// on done for one cycle, once the word has passed the output counters, the
// row times width address multiply, the frame store read port and the output
// register. The frame store holds MAX_DIM by MAX_DIM pixels and has no
// clearing pass after reset.
`include "frame_flip_rotate_invert_defines.svh"

module frame_flip_rotate_invert #(
	parameter int MAX_DIM     = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic [ffri_pkg::CHAN_W-1:0]      chan_a,
	input  logic [ffri_pkg::CHAN_W-1:0]      chan_b,
	input  logic [ffri_pkg::CHAN_W-1:0]      chan_c,
	input  logic                             wr_en,
	input  logic [ffri_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [ffri_pkg::CFG_DATA_W-1:0]  wr_data,
	output logic                             done,
	output logic [ffri_pkg::CHAN_W-1:0]      out_a,
	output logic [ffri_pkg::CHAN_W-1:0]      out_b,
	output logic [ffri_pkg::CHAN_W-1:0]      out_c,
	output logic                             last_pixel,
	output logic [ffri_pkg::STATUS_W-1:0]    status
);

	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LC_W   = $clog2(DEPTH + 1);
	localparam int PROD_W = 2 * DIM_W;
	localparam int DATA_W = 3 * SAMPLE_BITS;
	localparam int CW     = ffri_pkg::CHAN_W;
	localparam int LW     = ffri_pkg::LEVEL_W;
	localparam logic [LW-1:0] SAMPLE_MAX = LW'((64'd1 << SAMPLE_BITS) - 64'd1);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [ffri_pkg::DIM_CFG_W-1:0] v);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			res = DIM_W'(MAX_DIM);
		end else begin
			res = DIM_W'(v);
		end
		return res;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] clamp_chan(input logic [CW-1:0] v,
			input logic [LW-1:0] lim);
		logic [CW-1:0] res;
		res = (v > lim) ? lim : v;
		return res[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [CW-1:0] inv_chan(input logic [SAMPLE_BITS-1:0] v,
			input logic [LW-1:0] lim);
		logic [CW-1:0] res;
		res = (CW'(v) > lim) ? '0 : (lim - CW'(v));
		return res;
	endfunction

	logic [ffri_pkg::DIM_CFG_W-1:0] width_q, height_q, width_d, height_d;
	logic [LW-1:0]                  max_level_q;
	ffri_pkg::op_t                  op_q;
	logic                           color_q;
	logic [LC_W-1:0]                total_q;
	logic [PROD_W-1:0]              total_d;

	logic [LC_W-1:0]  load_count_q;
	logic [CNT_W-1:0] out_row_q, out_col_q;
	logic             clamp_seen_q;

	logic             in_load, in_read, complete, gray, rot, last_px, wrap;
	logic             clamp_a, clamp_bc;
	logic [LW-1:0]    lim;
	logic [DIM_W-1:0] eff_w, eff_h, ow, oh, row_x, col_x, r, c, sr, sc;

	logic                      wr_v_s1;
	logic [ADDR_W-1:0]         wr_addr_s1;
	logic [DATA_W-1:0]         wr_data_s1;
	logic                      rd_v_s1, rd_v_s2, rd_v_s3;
	ffri_pkg::rd_ctl_t         ctl_s1, ctl_s2, ctl_s3;
	logic [DIM_W-1:0]          sr_s1, sc_s1, w_s1;
	logic [PROD_W-1:0]         addr_full;
	logic [ADDR_W-1:0]         addr_s2;
	logic [DATA_W-1:0]         rd_data_s3;

	logic                      done_q, last_q;
	logic [CW-1:0]             out_a_q, out_b_q, out_c_q;
	ffri_pkg::status_t         status_q;

	assign busy    = 1'b0;
	assign in_load = start && !busy && !func;
	assign in_read = start && !busy && func;

	// Configuration registers and the frame size that follows them.
	always_comb begin
		width_d  = width_q;
		height_d = height_q;
		if (wr_en && (wr_index == ffri_pkg::REG_FRAME_WIDTH)) begin
			width_d = wr_data[ffri_pkg::DIM_CFG_W-1:0];
		end
		if (wr_en && (wr_index == ffri_pkg::REG_FRAME_HEIGHT)) begin
			height_d = wr_data[ffri_pkg::DIM_CFG_W-1:0];
		end
		total_d = PROD_W'(eff_dim(width_d)) * PROD_W'(eff_dim(height_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= ffri_pkg::DIM_CFG_W'(1);
			height_q    <= ffri_pkg::DIM_CFG_W'(1);
			max_level_q <= LW'(255);
			op_q        <= ffri_pkg::OP_INVERT;
			color_q     <= 1'b1;
			total_q     <= LC_W'(1);
		end else begin
			width_q  <= width_d;
			height_q <= height_d;
			total_q  <= total_d[LC_W-1:0];
			if (wr_en && (wr_index == ffri_pkg::REG_MAX_LEVEL)) begin
				max_level_q <= wr_data[LW-1:0];
			end
			if (wr_en && (wr_index == ffri_pkg::REG_OPERATION)) begin
				op_q <= wr_data[ffri_pkg::OP_W-1:0];
			end
			if (wr_en && (wr_index == ffri_pkg::REG_COLOR_MODE)) begin
				color_q <= wr_data[0];
			end
		end
	end

	// Output order: clamp the counters to the current output size, then map
	// the output position back to a source row and column.
	always_comb begin
		eff_w    = eff_dim(width_q);
		eff_h    = eff_dim(height_q);
		lim      = (max_level_q < SAMPLE_MAX) ? max_level_q : SAMPLE_MAX;
		complete = (load_count_q >= total_q);
		gray     = !color_q;
		rot      = (op_q == ffri_pkg::OP_ROT90) || (op_q == ffri_pkg::OP_ROT270);
		ow       = rot ? eff_h : eff_w;
		oh       = rot ? eff_w : eff_h;
		row_x    = DIM_W'(out_row_q);
		col_x    = DIM_W'(out_col_q);
		r        = (row_x < oh) ? row_x : (oh - DIM_W'(1));
		c        = (col_x < ow) ? col_x : (ow - DIM_W'(1));
		last_px  = (row_x >= oh) ||
			((row_x >= (oh - DIM_W'(1))) && (col_x >= (ow - DIM_W'(1))));
		wrap     = ((col_x + DIM_W'(1)) >= ow);
		clamp_a  = (chan_a > lim);
		clamp_bc = !gray && ((chan_b > lim) || (chan_c > lim));
		case (op_q)
			ffri_pkg::OP_MIRROR_H: begin
				sr = r;
				sc = eff_w - DIM_W'(1) - c;
			end
			ffri_pkg::OP_MIRROR_V: begin
				sr = eff_h - DIM_W'(1) - r;
				sc = c;
			end
			ffri_pkg::OP_ROT90: begin
				sr = eff_h - DIM_W'(1) - c;
				sc = r;
			end
			ffri_pkg::OP_ROT270: begin
				sr = c;
				sc = eff_w - DIM_W'(1) - r;
			end
			default: begin
				sr = r;
				sc = c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			clamp_seen_q <= 1'b0;
		end else if (in_load && !complete) begin
			load_count_q <= load_count_q + LC_W'(1);
			if (clamp_a || clamp_bc) begin
				clamp_seen_q <= 1'b1;
			end
		end else if (in_read && complete) begin
			if (last_px) begin
				load_count_q <= '0;
				out_row_q    <= '0;
				out_col_q    <= '0;
				clamp_seen_q <= 1'b0;
			end else if (wrap) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + CNT_W'(1);
			end else begin
				out_col_q <= out_col_q + CNT_W'(1);
			end
		end
	end

	// Stage 1: store write and read request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_s1 <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			wr_v_s1 <= in_load && !complete;
			rd_v_s1 <= in_read;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= load_count_q[ADDR_W-1:0];
		wr_data_s1 <= {gray ? SAMPLE_BITS'(0) : clamp_chan(chan_c, lim),
			gray ? SAMPLE_BITS'(0) : clamp_chan(chan_b, lim),
			clamp_chan(chan_a, lim)};
		sr_s1        <= sr;
		sc_s1        <= sc;
		w_s1         <= eff_w;
		ctl_s1.ready <= complete;
		ctl_s1.last  <= last_px;
		ctl_s1.clamp <= clamp_seen_q;
		ctl_s1.gray  <= gray;
		ctl_s1.inv   <= (op_q == ffri_pkg::OP_INVERT);
		ctl_s1.level <= lim;
	end

	// Stage 2: linear address.
	assign addr_full = PROD_W'(sr_s1) * PROD_W'(w_s1) + PROD_W'(sc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s2 <= 1'b0;
			rd_v_s3 <= 1'b0;
		end else begin
			rd_v_s2 <= rd_v_s1;
			rd_v_s3 <= rd_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2 <= addr_full[ADDR_W-1:0];
		ctl_s2  <= ctl_s1;
		ctl_s3  <= ctl_s2;
	end

	// Stage 3: frame store read.
	ffri_store #(
		.ADDR_W (ADDR_W),
		.DATA_W (DATA_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_v_s1),
		.wr_addr (wr_addr_s1),
		.wr_data (wr_data_s1),
		.rd_addr (addr_s2),
		.rd_data (rd_data_s3)
	);

	// Stage 4: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rd_v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl_s3.ready) begin
			out_a_q  <= '0;
			out_b_q  <= '0;
			out_c_q  <= '0;
			last_q   <= 1'b0;
			status_q <= ffri_pkg::ST_NOT_READY;
		end else begin
			out_a_q <= ctl_s3.inv ?
				inv_chan(rd_data_s3[SAMPLE_BITS-1:0], ctl_s3.level) :
				CW'(rd_data_s3[SAMPLE_BITS-1:0]);
			if (ctl_s3.gray) begin
				out_b_q <= '0;
				out_c_q <= '0;
			end else begin
				out_b_q <= ctl_s3.inv ?
					inv_chan(rd_data_s3[2*SAMPLE_BITS-1:SAMPLE_BITS], ctl_s3.level) :
					CW'(rd_data_s3[2*SAMPLE_BITS-1:SAMPLE_BITS]);
				out_c_q <= ctl_s3.inv ?
					inv_chan(rd_data_s3[DATA_W-1:2*SAMPLE_BITS], ctl_s3.level) :
					CW'(rd_data_s3[DATA_W-1:2*SAMPLE_BITS]);
			end
			last_q   <= ctl_s3.last;
			status_q <= ctl_s3.clamp ? ffri_pkg::ST_CLAMPED : ffri_pkg::ST_OK;
		end
	end

	assign done       = done_q;
	assign out_a      = out_a_q;
	assign out_b      = out_b_q;
	assign out_c      = out_c_q;
	assign last_pixel = last_q;
	assign status     = status_q;

	`FFRI_ASSERT_IMP(a_not_ready_blank, done && (status == ffri_pkg::ST_NOT_READY), (out_a == '0) && !last_pixel)
	`FFRI_ASSERT_NXT(a_full_load_dropped, in_load && complete, $stable(load_count_q))
	`FFRI_ASSERT_NXT(a_last_clears, in_read && complete && last_px, (load_count_q == '0) && (out_row_q == '0) && (out_col_q == '0) && !clamp_seen_q)
	`FFRI_ASSERT_IMP(a_count_bound, 1'b1, load_count_q <= LC_W'(DEPTH))

endmodule
